@@ sv/llsc_pkg.sv @@
`default_nettype none
package llsc_pkg;

  localparam int unsigned MAX_PARTS_PER_SEGMENT = 256;
  localparam int unsigned PART_IDX_LIMIT_INT =
    (MAX_PARTS_PER_SEGMENT - 1 > 255) ? 255 : MAX_PARTS_PER_SEGMENT - 1;
  localparam logic [7:0] PART_IDX_LIMIT = 8'(PART_IDX_LIMIT_INT);

  localparam int unsigned MS_TO_US    = 1000;
  localparam int unsigned EARLY_NUM   = 85;
  localparam int unsigned EARLY_DEN   = 100;
  localparam int unsigned EARLY_SCALE = EARLY_DEN * MS_TO_US;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 30;

  localparam logic [CFG_IDX_W-1:0] CFG_PART_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_TARGET  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_VIDEO   = 2'd2;

  localparam logic [25:0] PART_TARGET_RST = 26'd1000000;
  localparam logic [29:0] SEG_TARGET_RST  = 30'd6000000;
  localparam logic [32:0] EARLY_THR_RST   = 33'(64'(PART_TARGET_RST) * EARLY_NUM);

  localparam logic KIND_PART  = 1'b0;
  localparam logic KIND_CLOSE = 1'b1;

  typedef enum logic [1:0] {
    CMD_AUDIO = 2'd0,
    CMD_VIDEO = 2'd1,
    CMD_CODEC = 2'd2,
    CMD_EOS   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] dts;
    logic        keyframe;
  } item_t;

  // early_thr holds part_tgt * 85, kept alongside the target
  typedef struct packed {
    logic [25:0] part_tgt;
    logic [29:0] seg_target;
    logic        video_on;
    logic [32:0] early_thr;
  } cfg_t;

endpackage
`default_nettype wire

@@ sv/llsc_ifs.sv @@
`default_nettype none
interface llsc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] dts;
  logic        keyframe;
  modport source (output valid, output cmd, output dts, output keyframe, input ready);
  modport sink (input valid, input cmd, input dts, input keyframe, output ready);
endinterface

interface llsc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] segment_number;
  logic [7:0]  part_index;
  logic [41:0] part_duration_us;
  logic        independent;
  logic        closes_segment;
  modport source (output valid, output kind, output segment_number, output part_index,
                  output part_duration_us, output independent, output closes_segment,
                  input ready);
  modport sink (input valid, input kind, input segment_number, input part_index,
                input part_duration_us, input independent, input closes_segment,
                output ready);
endinterface
`default_nettype wire

@@ sv/llsc_cfg.sv @@
`default_nettype none
module llsc_cfg
  import llsc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.part_tgt    <= PART_TARGET_RST;
      cfg_r.seg_target  <= SEG_TARGET_RST;
      cfg_r.video_on    <= 1'b0;
      cfg_r.early_thr   <= EARLY_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_PART_TARGET: begin
          cfg_r.part_tgt    <= cfg_wdata[25:0];
          cfg_r.early_thr   <= 33'(cfg_wdata[25:0]) * 33'(EARLY_NUM);
        end
        CFG_SEG_TARGET: cfg_r.seg_target <= cfg_wdata[29:0];
        CFG_HAS_VIDEO:  cfg_r.video_on   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

@@ sv/llsc_in_stage.sv @@
`default_nettype none
module llsc_in_stage
  import llsc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  llsc_in_if.sink   in_ch,
  input  wire logic adv,
  output item_t     stg_item,
  output logic      stg_v
);

  logic  stg_v_r;
  item_t stg_item_r;

  assign in_ch.ready = !stg_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      stg_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stg_item_r.cmd      <= cmd_t'(in_ch.cmd);
      stg_item_r.dts      <= in_ch.dts;
      stg_item_r.keyframe <= in_ch.keyframe;
    end
  end

  assign stg_item = stg_item_r;
  assign stg_v    = stg_v_r;

endmodule
`default_nettype wire

@@ sv/llsc_cut.sv @@
`default_nettype none
module llsc_cut
  import llsc_pkg::*;
#(
  parameter int unsigned MAX_PARTS = MAX_PARTS_PER_SEGMENT
)
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  cfg_t       cfg,
  input  item_t      stg_item,
  input  wire logic  stg_v,
  output logic       adv,
  llsc_out_if.source out_ch
);

  localparam int unsigned IDX_LIMIT_INT = (MAX_PARTS - 1 > 255) ? 255 : MAX_PARTS - 1;
  localparam logic [7:0]  IDX_LIMIT     = 8'(IDX_LIMIT_INT);

  // cutter state
  logic        part_open_r, part_open_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] prev_r, prev_nxt;
  logic        saw_video_r, saw_video_nxt;
  logic        first_key_r, first_key_nxt;
  logic [47:0] accum_r, accum_nxt;
  logic        seg_open_r, seg_open_nxt;
  logic [31:0] next_seg_r, next_seg_nxt;
  logic [31:0] cur_seg_r, cur_seg_nxt;
  logic [7:0]  parts_r, parts_nxt;

  // result register
  logic        out_v_r, out_v_nxt;
  logic        kind_r, kind_nxt;
  logic [31:0] seg_num_r, seg_num_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [41:0] dur_r, dur_nxt;
  logic        indep_r, indep_nxt;
  logic        close_r, close_nxt;

  logic        is_frame, is_video, may_end;
  logic [31:0] end_ms, d_ms, g_ms;
  logic [32:0] sum_ms;
  logic [41:0] pdur;
  logic [42:0] pg;
  logic [48:0] acc_sum;
  logic [49:0] early_lhs;
  logic        seg_hit, full_hit, early_hit;
  logic        do_emit, do_close, do_seg_only, res_v;
  logic        part_open_mid, saw_video_mid;
  logic [7:0]  idx;

  assign adv = stg_v && (!out_v_r || out_ch.ready);

  assign is_video = (stg_item.cmd == CMD_VIDEO);
  assign is_frame = is_video || (stg_item.cmd == CMD_AUDIO);
  assign may_end  = is_video ? stg_item.keyframe : !cfg.video_on;

  // codec change and end of stream close the part at the last frame time
  assign end_ms = is_frame ? stg_item.dts : prev_r;
  assign d_ms   = (end_ms > start_r) ? end_ms - start_r : '0;
  assign g_ms   = (stg_item.dts > prev_r) ? stg_item.dts - prev_r : '0;
  assign sum_ms = {1'b0, d_ms} + {1'b0, g_ms};

  assign pdur      = 42'(d_ms) * 42'(MS_TO_US);
  assign pg        = 43'(sum_ms) * 43'(MS_TO_US);
  assign early_lhs = 50'(d_ms) * 50'(EARLY_SCALE) + 50'(EARLY_DEN - 1);
  assign acc_sum   = {1'b0, accum_r} + 49'(pdur);

  assign seg_hit   = may_end && (acc_sum >= 49'(cfg.seg_target));
  assign full_hit  = pdur >= 42'(cfg.part_tgt);
  // floor(tgt*85/100) <= pdur, written without a divider; part+gap > tgt
  assign early_hit = (early_lhs >= 50'(cfg.early_thr)) && (pg > 43'(cfg.part_tgt));

  assign idx = seg_open_r ? parts_r : '0;

  always_comb begin
    do_emit     = 1'b0;
    do_close    = 1'b0;
    do_seg_only = 1'b0;
    case (stg_item.cmd) inside
      CMD_AUDIO, CMD_VIDEO: begin
        do_emit  = part_open_r && (seg_hit || full_hit || early_hit);
        do_close = seg_hit;
      end
      CMD_CODEC: begin
        do_emit  = part_open_r;
        do_close = 1'b1;
      end
      default: begin
        do_emit     = part_open_r;
        do_close    = 1'b1;
        do_seg_only = !part_open_r && seg_open_r;
      end
    endcase
  end

  assign res_v = do_emit || do_seg_only;

  always_comb begin
    part_open_nxt = part_open_r;
    start_nxt     = start_r;
    prev_nxt      = prev_r;
    saw_video_nxt = saw_video_r;
    first_key_nxt = first_key_r;
    accum_nxt     = accum_r;
    seg_open_nxt  = seg_open_r;
    next_seg_nxt  = next_seg_r;
    cur_seg_nxt   = cur_seg_r;
    parts_nxt     = parts_r;

    kind_nxt    = KIND_PART;
    seg_num_nxt = seg_open_r ? cur_seg_r : next_seg_r;
    idx_nxt     = idx;
    dur_nxt     = pdur;
    indep_nxt   = saw_video_r ? first_key_r : !cfg.video_on;
    close_nxt   = do_close;

    if (do_emit) begin
      if (!seg_open_r) begin
        cur_seg_nxt  = next_seg_r;
        next_seg_nxt = next_seg_r + 32'd1;
      end
      parts_nxt = (idx < IDX_LIMIT) ? idx + 8'd1 : idx;
      if (do_close) begin
        seg_open_nxt = 1'b0;
        accum_nxt    = '0;
      end else begin
        seg_open_nxt = 1'b1;
        accum_nxt    = acc_sum[48] ? '1 : acc_sum[47:0];
      end
      part_open_nxt = 1'b0;
      saw_video_nxt = 1'b0;
      first_key_nxt = 1'b0;
    end

    if (do_seg_only) begin
      kind_nxt     = KIND_CLOSE;
      seg_num_nxt  = cur_seg_r;
      idx_nxt      = '0;
      dur_nxt      = '0;
      indep_nxt    = 1'b0;
      close_nxt    = 1'b1;
      seg_open_nxt = 1'b0;
      accum_nxt    = '0;
    end

    part_open_mid = part_open_r && !do_emit;
    saw_video_mid = saw_video_r && !do_emit;
    if (is_frame) begin
      if (!part_open_mid) begin
        part_open_nxt = 1'b1;
        start_nxt     = stg_item.dts;
        saw_video_nxt = 1'b0;
        first_key_nxt = 1'b0;
      end
      if (is_video && !(part_open_mid && saw_video_mid)) begin
        saw_video_nxt = 1'b1;
        first_key_nxt = stg_item.keyframe;
      end
      prev_nxt = stg_item.dts;
    end
  end

  always_comb begin
    if (adv) begin
      out_v_nxt = res_v;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_open_r <= 1'b0;
      start_r     <= '0;
      prev_r      <= '0;
      saw_video_r <= 1'b0;
      first_key_r <= 1'b0;
      accum_r     <= '0;
      seg_open_r  <= 1'b0;
      next_seg_r  <= '0;
      cur_seg_r   <= '0;
      parts_r     <= '0;
      out_v_r     <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      if (adv) begin
        part_open_r <= part_open_nxt;
        start_r     <= start_nxt;
        prev_r      <= prev_nxt;
        saw_video_r <= saw_video_nxt;
        first_key_r <= first_key_nxt;
        accum_r     <= accum_nxt;
        seg_open_r  <= seg_open_nxt;
        next_seg_r  <= next_seg_nxt;
        cur_seg_r   <= cur_seg_nxt;
        parts_r     <= parts_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_v) begin
      kind_r    <= kind_nxt;
      seg_num_r <= seg_num_nxt;
      idx_r     <= idx_nxt;
      dur_r     <= dur_nxt;
      indep_r   <= indep_nxt;
      close_r   <= close_nxt;
    end
  end

  assign out_ch.valid            = out_v_r;
  assign out_ch.kind             = kind_r;
  assign out_ch.segment_number   = seg_num_r;
  assign out_ch.part_index       = idx_r;
  assign out_ch.part_duration_us = dur_r;
  assign out_ch.independent      = indep_r;
  assign out_ch.closes_segment   = close_r;

endmodule
`default_nettype wire

@@ sv/low_latency_segment_cutter.sv @@
// Partial segment cutter for low-latency streaming.
// in_ch carries frame events (cmd, dts in ms, keyframe) with valid/ready;
// out_ch carries at most one cut record per event (kind, segment_number,
// part_index, part_duration_us, independent, closes_segment).
// cfg_we/cfg_idx/cfg_wdata write the part target, segment target and the
// video-present flag; write them while no event is in flight.
// An event lands in an input register, is decided combinationally against the
// cutter state, and its record is registered in the result register, which
// drives out_ch.valid. One event per cycle is sustained while out_ch is ready;
// the combinational state update between the two registers sets that rate.
// Events that produce no record still take their slot at that rate.
// When out_ch stalls, the result register holds its record; at most one more
// event is taken into the input register, then in_ch.ready drops until the record
// is taken.
// Reset (rst_n low, synchronous) restores the default targets, closes any
// open part and segment and restarts numbering at zero.
`default_nettype none
module low_latency_segment_cutter
  import llsc_pkg::*;
#(
  parameter int unsigned MAX_PARTS = MAX_PARTS_PER_SEGMENT
)
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  llsc_in_if.sink                    in_ch,
  llsc_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t  cfg;
  item_t stg_item;
  logic  stg_v;
  logic  adv;

  llsc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  llsc_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .adv      (adv),
    .stg_item (stg_item),
    .stg_v    (stg_v)
  );

  llsc_cut #(
    .MAX_PARTS (MAX_PARTS)
  ) u_cut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .stg_item (stg_item),
    .stg_v    (stg_v),
    .adv      (adv),
    .out_ch   (out_ch)
  );

`ifndef SYNTHESIS
  a_no_adv_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !adv)
    else $error("input stage advanced over a stalled result");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> stg_v)
    else $error("input blocked with an empty input register");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> stg_v)
    else $error("accepted item lost from input register");

  a_close_record: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind == KIND_CLOSE) |->
      (out_ch.closes_segment && out_ch.part_duration_us == '0 && out_ch.part_index == '0))
    else $error("segment close record carries part data");
`endif

endmodule
`default_nettype wire
